[src/sar_pkg.sv]
// shared types and constants for the scroll address register unit
`default_nettype none

package sar_pkg;

    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned ACCESS_W = 14;
    localparam int unsigned FINE_W   = 3;
    localparam int unsigned COARSE_W = 5;
    localparam int unsigned MODE_W   = 4;
    localparam int unsigned DATA_W   = 8;

    localparam logic [COARSE_W-1:0] COARSE_X_LAST   = 5'd31;
    localparam logic [COARSE_W-1:0] COARSE_Y_LAST   = 5'd29;
    localparam logic [COARSE_W-1:0] COARSE_Y_SPILL  = 5'd31;
    localparam logic [FINE_W-1:0]   FINE_Y_LAST     = 3'd7;
    localparam logic [ADDR_W-1:0]   STEP_ROW        = 16'd32;
    localparam logic [ADDR_W-1:0]   STEP_ONE        = 16'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_CTRL_WR   = 4'd0,
        MODE_MASK_WR   = 4'd1,
        MODE_SCROLL_WR = 4'd2,
        MODE_ADDR_WR   = 4'd3,
        MODE_DATA_WR   = 4'd4,
        MODE_DATA_RD   = 4'd5,
        MODE_STATUS_RD = 4'd6,
        MODE_INC_X     = 4'd7,
        MODE_INC_Y     = 4'd8,
        MODE_COPY_X    = 4'd9,
        MODE_COPY_Y    = 4'd10
    } t_mode;

endpackage

`default_nettype wire

[src/scroll_address_register_unit.sv]
// top level of the scroll address register unit
`default_nettype none

// Takes one beat per cycle while o_stall is low and returns one result beat
// per input beat: each beat is held in the input register, then the field
// update of the address, scroll and toggle registers loads the result
// register. The state registers change only when a result loads, so the
// next beat always sees the state left by the one before it. A stall on
// the result side holds the result register and, when the input register
// is also full, stalls the input side in the same cycle.
module scroll_address_register_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [sar_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [sar_pkg::DATA_W-1:0]       i_data,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [sar_pkg::ADDR_W-1:0]            o_current_address,
    output logic [sar_pkg::ADDR_W-1:0]            o_temp_address,
    output logic [sar_pkg::FINE_W-1:0]            o_fine_scroll_x,
    output logic                                  o_toggle,
    output logic                                  o_access_valid,
    output logic                                  o_access_write,
    output logic [sar_pkg::ACCESS_W-1:0]          o_access_address
);

    logic                          r_in_valid;
    sar_pkg::t_mode                r_mode;
    logic [sar_pkg::DATA_W-1:0]    r_data;
    logic                          r_out_valid;

    logic [sar_pkg::ADDR_W-1:0]    r_cur;
    logic [sar_pkg::ADDR_W-1:0]    r_tmp;
    logic [sar_pkg::FINE_W-1:0]    r_fine_x;
    logic                          r_toggle;
    logic                          r_inc32;
    logic                          r_render;
    logic                          r_acc_valid;
    logic                          r_acc_write;
    logic [sar_pkg::ACCESS_W-1:0]  r_acc_addr;

    logic [sar_pkg::ADDR_W-1:0]    n_cur;
    logic [sar_pkg::ADDR_W-1:0]    n_tmp;
    logic [sar_pkg::FINE_W-1:0]    n_fine_x;
    logic                          n_toggle;
    logic                          n_inc32;
    logic                          n_render;
    logic                          n_acc_valid;
    logic                          n_acc_write;

    logic                          out_free;
    logic                          process;
    logic [sar_pkg::COARSE_W-1:0]  tile_col;
    logic [sar_pkg::COARSE_W-1:0]  tile_row;
    logic [sar_pkg::FINE_W-1:0]    fine_y;

    assign out_free = !r_out_valid || !i_stall;
    assign process  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    assign tile_col = r_cur[4:0];
    assign tile_row = r_cur[9:5];
    assign fine_y   = r_cur[14:12];

    always_comb begin
        n_cur       = r_cur;
        n_tmp       = r_tmp;
        n_fine_x    = r_fine_x;
        n_toggle    = r_toggle;
        n_inc32     = r_inc32;
        n_render    = r_render;
        n_acc_valid = 1'b0;
        n_acc_write = 1'b0;
        case (r_mode)
            sar_pkg::MODE_CTRL_WR: begin
                n_inc32       = r_data[2];
                n_tmp[11:10]  = r_data[1:0];
            end
            sar_pkg::MODE_MASK_WR: begin
                n_render = r_data[3] || r_data[4];
            end
            sar_pkg::MODE_SCROLL_WR: begin
                if (!r_toggle) begin
                    n_fine_x   = r_data[2:0];
                    n_tmp[4:0] = r_data[7:3];
                end else begin
                    n_tmp[14:12] = r_data[2:0];
                    n_tmp[9:5]   = r_data[7:3];
                end
                n_toggle = !r_toggle;
            end
            sar_pkg::MODE_ADDR_WR: begin
                if (!r_toggle) begin
                    n_tmp = {2'b00, r_data[5:0], r_tmp[7:0]};
                end else begin
                    n_tmp = {r_tmp[15:8], r_data};
                    n_cur = {r_tmp[15:8], r_data};
                end
                n_toggle = !r_toggle;
            end
            sar_pkg::MODE_DATA_WR, sar_pkg::MODE_DATA_RD: begin
                n_acc_valid = 1'b1;
                n_acc_write = (r_mode == sar_pkg::MODE_DATA_WR);
                n_cur = r_cur + (r_inc32 ? sar_pkg::STEP_ROW : sar_pkg::STEP_ONE);
            end
            sar_pkg::MODE_STATUS_RD: begin
                n_toggle = 1'b0;
            end
            sar_pkg::MODE_INC_X: begin
                if (r_render) begin
                    if (tile_col == sar_pkg::COARSE_X_LAST) begin
                        n_cur[4:0] = '0;
                        n_cur[10]  = !r_cur[10];
                    end else begin
                        n_cur[4:0] = tile_col + 5'd1;
                    end
                end
            end
            sar_pkg::MODE_INC_Y: begin
                if (r_render) begin
                    if (fine_y != sar_pkg::FINE_Y_LAST) begin
                        n_cur[14:12] = fine_y + 3'd1;
                    end else begin
                        n_cur[14:12] = '0;
                        if (tile_row == sar_pkg::COARSE_Y_LAST) begin
                            n_cur[9:5] = '0;
                            n_cur[11]  = !r_cur[11];
                        end else if (tile_row == sar_pkg::COARSE_Y_SPILL) begin
                            n_cur[9:5] = '0;
                        end else begin
                            n_cur[9:5] = tile_row + 5'd1;
                        end
                    end
                end
            end
            sar_pkg::MODE_COPY_X: begin
                if (r_render) begin
                    n_cur[10]  = r_tmp[10];
                    n_cur[4:0] = r_tmp[4:0];
                end
            end
            sar_pkg::MODE_COPY_Y: begin
                if (r_render) begin
                    n_cur[14:11] = r_tmp[14:11];
                    n_cur[9:5]   = r_tmp[9:5];
                end
            end
            default: begin
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_mode <= sar_pkg::t_mode'(i_mode);
            r_data <= i_data;
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            r_tmp       <= '0;
            r_fine_x    <= '0;
            r_toggle    <= 1'b0;
            r_inc32     <= 1'b0;
            r_render    <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (process) begin
                r_cur    <= n_cur;
                r_tmp    <= n_tmp;
                r_fine_x <= n_fine_x;
                r_toggle <= n_toggle;
                r_inc32  <= n_inc32;
                r_render <= n_render;
            end
        end
        if (process) begin
            r_acc_valid <= n_acc_valid;
            r_acc_write <= n_acc_write;
            r_acc_addr  <= n_acc_valid ? r_cur[sar_pkg::ACCESS_W-1:0] : '0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_current_address = r_cur;
    assign o_temp_address    = r_tmp;
    assign o_fine_scroll_x   = r_fine_x;
    assign o_toggle          = r_toggle;
    assign o_access_valid    = r_acc_valid;
    assign o_access_write    = r_acc_write;
    assign o_access_address  = r_acc_addr;

    // status read leaves the toggle cleared
    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && r_mode == sar_pkg::MODE_STATUS_RD |=> !r_toggle)
        else $error("toggle not cleared by status read");

    // render events leave the current address alone while rendering is off
    a_render_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && !r_render && (r_mode == sar_pkg::MODE_INC_X ||
        r_mode == sar_pkg::MODE_INC_Y || r_mode == sar_pkg::MODE_COPY_X ||
        r_mode == sar_pkg::MODE_COPY_Y) |=> $stable(r_cur))
        else $error("current address moved with rendering off");

    // a data access reports the address before its increment
    a_access_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && (r_mode == sar_pkg::MODE_DATA_WR || r_mode == sar_pkg::MODE_DATA_RD)
        |=> r_acc_valid && r_acc_addr == $past(r_cur[sar_pkg::ACCESS_W-1:0]))
        else $error("access address mismatch");

    // the input side never stalls while the result register can load
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_stall)
        else $error("stall with empty result register");

endmodule

`default_nettype wire

[verif/scroll_address_register_unit_tb.sv]
// testbench for the scroll address register unit, checked beat by beat against a field model
`timescale 1ns / 1ps

module scroll_address_register_unit_tb;
    import sar_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 4'd11;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 4'd15;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_BEATS = 240;
    localparam int SWEEP_BEATS = 1030;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] data;
        bit                hold;
    } t_beat;

    typedef struct packed {
        logic [ADDR_W-1:0]   cur;
        logic [ADDR_W-1:0]   tmp;
        logic [FINE_W-1:0]   fine_x;
        logic                tog;
        logic                acc_valid;
        logic                acc_write;
        logic [ACCESS_W-1:0] acc_addr;
    } t_scroll_snap;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [MODE_W-1:0]   i_mode = '0;
    logic [DATA_W-1:0]   i_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [ADDR_W-1:0]   o_current_address;
    logic [ADDR_W-1:0]   o_temp_address;
    logic [FINE_W-1:0]   o_fine_scroll_x;
    logic                o_toggle;
    logic                o_access_valid;
    logic                o_access_write;
    logic [ACCESS_W-1:0] o_access_address;

    scroll_address_register_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_data            (i_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_current_address (o_current_address),
        .o_temp_address    (o_temp_address),
        .o_fine_scroll_x   (o_fine_scroll_x),
        .o_toggle          (o_toggle),
        .o_access_valid    (o_access_valid),
        .o_access_write    (o_access_write),
        .o_access_address  (o_access_address)
    );

    // model copy of the unit's registers
    logic [DATA_W-1:0] ctrl_r   = '0;
    logic [DATA_W-1:0] mask_r   = '0;
    logic [ADDR_W-1:0] cur_r    = '0;
    logic [ADDR_W-1:0] tmp_r    = '0;
    logic [FINE_W-1:0] finex_r  = '0;
    logic              tog_r    = 1'b0;

    t_beat        beats_todo[$];
    t_scroll_snap snapshots_due[$];

    int  n_sent = 0;
    int  n_done = 0;
    int  src_gap = 0;
    int  snk_gap = 0;
    int  src_idle_rate = 2;
    int  snk_idle_rate = 2;
    int  cycle_count = 0;
    int  n_queued = 0;
    bit  hold_pending = 1'b0;
    bit  winding_down = 1'b0;
    bit  failed = 1'b0;
    bit  beat_taken;

    function automatic t_scroll_snap step_scroll_regs(logic [MODE_W-1:0] mode,
                                                      logic [DATA_W-1:0] d);
        t_scroll_snap s;
        logic rendering;
        rendering = |mask_r[4:3];
        s = '0;
        case (mode)
            MODE_CTRL_WR: begin
                ctrl_r = d;
                tmp_r[11:10] = d[1:0];
            end
            MODE_MASK_WR: mask_r = d;
            MODE_SCROLL_WR: begin
                if (!tog_r) begin
                    finex_r = d[2:0];
                    tmp_r[4:0] = d[7:3];
                end else begin
                    tmp_r[14:12] = d[2:0];
                    tmp_r[9:5] = d[7:3];
                end
                tog_r = ~tog_r;
            end
            MODE_ADDR_WR: begin
                if (!tog_r) begin
                    tmp_r[15:8] = {2'b00, d[5:0]};
                end else begin
                    tmp_r[7:0] = d;
                    cur_r = tmp_r;
                end
                tog_r = ~tog_r;
            end
            MODE_DATA_WR, MODE_DATA_RD: begin
                s.acc_valid = 1'b1;
                s.acc_write = (mode == MODE_DATA_WR);
                s.acc_addr = cur_r[ACCESS_W-1:0];
                cur_r = cur_r + (ctrl_r[2] ? STEP_ROW : STEP_ONE);
            end
            MODE_STATUS_RD: tog_r = 1'b0;
            MODE_INC_X: begin
                if (rendering) begin
                    if (cur_r[4:0] == COARSE_X_LAST) begin
                        cur_r[4:0] = '0;
                        cur_r[10] = ~cur_r[10];
                    end else begin
                        cur_r[4:0] = cur_r[4:0] + 5'd1;
                    end
                end
            end
            MODE_INC_Y: begin
                if (rendering) begin
                    if (cur_r[14:12] != FINE_Y_LAST) begin
                        cur_r[14:12] = cur_r[14:12] + 3'd1;
                    end else begin
                        cur_r[14:12] = '0;
                        if (cur_r[9:5] == COARSE_Y_LAST) begin
                            cur_r[9:5] = '0;
                            cur_r[11] = ~cur_r[11];
                        end else if (cur_r[9:5] == COARSE_Y_SPILL) begin
                            cur_r[9:5] = '0;
                        end else begin
                            cur_r[9:5] = cur_r[9:5] + 5'd1;
                        end
                    end
                end
            end
            MODE_COPY_X: begin
                if (rendering) begin
                    cur_r[10] = tmp_r[10];
                    cur_r[4:0] = tmp_r[4:0];
                end
            end
            MODE_COPY_Y: begin
                if (rendering) begin
                    cur_r[14:12] = tmp_r[14:12];
                    cur_r[11] = tmp_r[11];
                    cur_r[9:5] = tmp_r[9:5];
                end
            end
            default: ;
        endcase
        s.cur = cur_r;
        s.tmp = tmp_r;
        s.fine_x = finex_r;
        s.tog = tog_r;
        return s;
    endfunction

    function automatic void queue_beat(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] data);
        t_beat b;
        b.mode = mode;
        b.data = data;
        b.hold = hold_pending;
        hold_pending = 1'b0;
        beats_todo.push_back(b);
        n_queued++;
    endfunction

    function automatic logic [4:0] pick_coarse_y();
        case ($urandom_range(0, 4))
            0: return COARSE_Y_LAST;
            1: return COARSE_Y_SPILL;
            2: return COARSE_Y_LAST - 5'd1;
            3: return COARSE_Y_SPILL - 5'd1;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic void queue_random_segment();
        logic [DATA_W-1:0] d;
        int n;
        case ($urandom_range(0, 9))
            0, 1: begin
                n = $urandom_range(1, 4);
                repeat (n) queue_beat(MODE_W'($urandom_range(0, 15)), DATA_W'($urandom));
            end
            2, 3, 4: begin
                if ($urandom_range(0, 3) != 0) queue_beat(MODE_STATUS_RD, DATA_W'($urandom));
                d = DATA_W'($urandom);
                if ($urandom_range(0, 5) != 0) d[3 + $urandom_range(0, 1)] = 1'b1;
                queue_beat(MODE_MASK_WR, d);
                queue_beat(MODE_SCROLL_WR, DATA_W'($urandom));
                d = {pick_coarse_y(), $urandom_range(0, 1) ? FINE_Y_LAST : FINE_W'($urandom)};
                queue_beat(MODE_SCROLL_WR, d);
                queue_beat(MODE_COPY_X, DATA_W'($urandom));
                queue_beat(MODE_COPY_Y, DATA_W'($urandom));
                n = $urandom_range(1, 40);
                repeat (n) begin
                    case ($urandom_range(0, 7))
                        0, 1, 2: queue_beat(MODE_INC_X, DATA_W'($urandom));
                        3, 4, 5: queue_beat(MODE_INC_Y, DATA_W'($urandom));
                        6: queue_beat(MODE_COPY_X, DATA_W'($urandom));
                        default: queue_beat(MODE_COPY_Y, DATA_W'($urandom));
                    endcase
                end
            end
            5, 6: begin
                queue_beat(MODE_STATUS_RD, DATA_W'($urandom));
                queue_beat(MODE_CTRL_WR, DATA_W'($urandom));
                queue_beat(MODE_ADDR_WR, DATA_W'($urandom));
                queue_beat(MODE_ADDR_WR, DATA_W'($urandom));
                n = $urandom_range(1, 20);
                repeat (n) begin
                    queue_beat($urandom_range(0, 1) ? MODE_DATA_WR : MODE_DATA_RD,
                               DATA_W'($urandom));
                end
            end
            7: begin
                d = DATA_W'($urandom);
                d[4:3] = 2'b00;
                queue_beat(MODE_MASK_WR, d);
                n = $urandom_range(1, 6);
                repeat (n) queue_beat(MODE_W'(MODE_INC_X + $urandom_range(0, 3)),
                                      DATA_W'($urandom));
            end
            8: queue_beat(MODE_CTRL_WR, DATA_W'($urandom));
            default: begin
                // lone writes leave the toggle mid-sequence
                queue_beat($urandom_range(0, 1) ? MODE_SCROLL_WR : MODE_ADDR_WR,
                           DATA_W'($urandom));
            end
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            failed = 1'b1;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            beat_taken = i_valid && !o_stall;
            if (beat_taken) begin
                snapshots_due.push_back(step_scroll_regs(i_mode, i_data));
                n_sent <= n_sent + 1;
            end
            winding_down <= (beats_todo.size() < 150);
            if (!i_valid || beat_taken) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    i_valid <= 1'b0;
                end else if (beats_todo.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (beats_todo[0].hold && (beat_taken || n_sent != n_done)) begin
                    i_valid <= 1'b0;
                end else if (!winding_down && $urandom_range(0, 7) < src_idle_rate) begin
                    src_gap <= $urandom_range(0, 16);
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    i_mode <= beats_todo[0].mode;
                    i_data <= beats_todo[0].data;
                    void'(beats_todo.pop_front());
                    if ($urandom_range(0, 63) == 0) src_idle_rate <= $urandom_range(0, 3);
                end
            end
        end
    end

    // monitor and result-side stall
    always @(posedge i_clk) begin
        t_scroll_snap want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (snapshots_due.size() == 0) begin
                    failed = 1'b1;
                    $error("result beat with no expected result pending");
                end else begin
                    want = snapshots_due.pop_front();
                    n_done <= n_done + 1;
                    check_field("current_address", want.cur, o_current_address);
                    check_field("temp_address", want.tmp, o_temp_address);
                    check_field("fine_scroll_x", want.fine_x, o_fine_scroll_x);
                    check_field("toggle", want.tog, o_toggle);
                    check_field("access_valid", want.acc_valid, o_access_valid);
                    check_field("access_write", want.acc_write, o_access_write);
                    check_field("access_address", want.acc_addr, o_access_address);
                end
            end
            if (snk_gap != 0) begin
                snk_gap <= snk_gap - 1;
                i_stall <= 1'b1;
            end else if (!winding_down && $urandom_range(0, 7) < snk_idle_rate) begin
                snk_gap <= $urandom_range(0, 16);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
            if ($urandom_range(0, 127) == 0) snk_idle_rate <= $urandom_range(0, 3);
        end
    end

    initial begin
        // corner cases
        queue_beat(MODE_CTRL_WR, 8'hFF);
        queue_beat(MODE_MASK_WR, 8'h08);
        queue_beat(MODE_SCROLL_WR, 8'hFF);
        queue_beat(MODE_SCROLL_WR, {COARSE_Y_LAST, FINE_Y_LAST});
        queue_beat(MODE_COPY_X, 8'h00);
        queue_beat(MODE_COPY_Y, 8'hFF);
        queue_beat(MODE_INC_X, 8'h00);
        queue_beat(MODE_INC_Y, 8'hFF);
        queue_beat(MODE_SCROLL_WR, 8'h00);
        queue_beat(MODE_SCROLL_WR, {COARSE_Y_SPILL, FINE_Y_LAST});
        queue_beat(MODE_COPY_Y, 8'h00);
        queue_beat(MODE_INC_Y, 8'h00);
        queue_beat(MODE_MASK_WR, 8'h10);
        queue_beat(MODE_INC_X, 8'hFF);
        queue_beat(MODE_MASK_WR, 8'h00);
        queue_beat(MODE_INC_Y, 8'h00);
        queue_beat(MODE_COPY_X, 8'hFF);
        queue_beat(MODE_STATUS_RD, 8'hFF);
        queue_beat(MODE_ADDR_WR, 8'hFF);
        queue_beat(MODE_ADDR_WR, 8'hFF);
        queue_beat(MODE_DATA_WR, 8'hFF);
        queue_beat(MODE_CTRL_WR, 8'h00);
        queue_beat(MODE_DATA_RD, 8'h00);
        queue_beat(MODE_UNDEF_LO, 8'hFF);
        queue_beat(MODE_UNDEF_HI, 8'h00);

        // copies load the current address with all scroll fields at their top,
        // then a row-step sweep runs through bit 15 and past the wrap
        hold_pending = 1'b1;
        queue_beat(MODE_STATUS_RD, 8'h00);
        queue_beat(MODE_MASK_WR, 8'h18);
        queue_beat(MODE_CTRL_WR, 8'h07);
        queue_beat(MODE_SCROLL_WR, 8'hF8);
        queue_beat(MODE_SCROLL_WR, 8'hFF);
        queue_beat(MODE_COPY_X, 8'h00);
        queue_beat(MODE_COPY_Y, 8'h00);
        repeat (SWEEP_BEATS) begin
            queue_beat($urandom_range(0, 1) ? MODE_DATA_WR : MODE_DATA_RD, DATA_W'($urandom));
        end

        n_queued = 0;
        while (n_queued < RANDOM_BEATS) begin
            if (n_queued % 400 < 10 && $urandom_range(0, 3) == 0) hold_pending = 1'b1;
            queue_random_segment();
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (beats_todo.size() != 0 || i_valid || n_done != n_sent) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (snapshots_due.size() != 0) begin
            $error("%0d expected results never arrived", snapshots_due.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
